// ===== rtl/sdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and codes for the serial packet deframer
// Transfer payloads, configuration record, parse phases and result kinds.
// ----------------------------------------------------------------------------
package sdf_pkg;

   // item kinds on the request channel
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;
   localparam logic [1:0] KIND_ABORT   = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   // register reset values
   localparam logic [7:0]  PREAMBLE_FIRST_RST  = 8'd170;
   localparam logic [7:0]  PREAMBLE_SECOND_RST = 8'd85;
   localparam logic [15:0] TIMEOUT_TICKS_RST   = 16'd10;

   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [5:0] payload_index;
      logic [7:0] frame_type;
      logic [7:0] frame_length;
      logic [7:0] frame_id;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  preamble_first;
      logic [7:0]  preamble_second;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_PRE2 = 8'b0000_0010,
      PH_TYPE = 8'b0000_0100,
      PH_LEN  = 8'b0000_1000,
      PH_ID   = 8'b0001_0000,
      PH_PAD  = 8'b0010_0000,
      PH_DATA = 8'b0100_0000,
      PH_CSUM = 8'b1000_0000
   } phase_type;

endpackage
`default_nettype wire

// ===== rtl/sdf_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_csr: configuration registers
// Write-only register file for preambles and timeout.
// ----------------------------------------------------------------------------
module sdf_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [sdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sdf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output sdf_pkg::cfg_type                    cfg
);
   import sdf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PREAMBLE_FIRST:  cfg_in.preamble_first  = csr_wdata[7:0];
            CSR_PREAMBLE_SECOND: cfg_in.preamble_second = csr_wdata[7:0];
            CSR_TIMEOUT_TICKS:   cfg_in.timeout_ticks   = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_first  <= PREAMBLE_FIRST_RST;
         cfg_ff.preamble_second <= PREAMBLE_SECOND_RST;
         cfg_ff.timeout_ticks   <= TIMEOUT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/sdf_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_in_stage: request input register
// Holds one accepted item until the parser can take it.
// ----------------------------------------------------------------------------
module sdf_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sdf_pkg::req_type req_data,
   input  wire logic             advance,
   output logic                  item_valid,
   output sdf_pkg::req_type      item
);
   import sdf_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;

   // slot frees when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule
`default_nettype wire

// ===== rtl/sdf_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_parser: frame parse state and per-item step
// One item per cycle while step_valid is high: phase step, 8-bit running sum, inter-byte timer.
// ----------------------------------------------------------------------------
module sdf_parser #(
   parameter int unsigned BUFFER_BYTES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sdf_pkg::cfg_type cfg,
   input  wire logic             step_valid,
   input  wire sdf_pkg::req_type item,
   output logic                  res_valid,
   output sdf_pkg::rsp_type      res
);
   import sdf_pkg::*;

   localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in, count_next;
   logic [7:0]       sum_ff, sum_in, sum_next;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       id_ff, id_in;
   logic [15:0]      ticks_ff, ticks_in, ticks_inc;
   logic             timer_ff, timer_in;

   logic [7:0] c;
   logic       expire;

   assign c          = item.rx_byte;
   assign sum_next   = sum_ff + c;
   assign count_next = count_ff + 1'b1;
   assign ticks_inc  = (ticks_ff == TICKS_MAX) ? ticks_ff : ticks_ff + 16'd1;
   assign expire     = ticks_inc >= cfg.timeout_ticks;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      id_in     = id_ff;
      ticks_in  = ticks_ff;
      timer_in  = timer_ff;
      res_valid = 1'b0;
      res.kind          = KIND_ABORT;
      res.payload_byte  = 8'd0;
      res.payload_index = 6'd0;
      res.frame_type    = type_ff;
      res.frame_length  = len_ff;
      res.frame_id      = id_ff;

      if (step_valid) begin
         if (item.func == FUNC_TICK) begin
            if (timer_ff) begin
               if (expire) begin
                  phase_in  = PH_IDLE;
                  timer_in  = 1'b0;
                  ticks_in  = 16'd0;
                  res_valid = 1'b1;
               end else begin
                  ticks_in = ticks_inc;
               end
            end
         end else begin
            timer_in = 1'b1;
            ticks_in = 16'd0;
            case (phase_ff)
               PH_IDLE: begin
                  if (c == cfg.preamble_first) begin
                     phase_in = PH_PRE2;
                     sum_in   = c;
                  end else begin
                     timer_in = 1'b0;
                  end
               end
               PH_PRE2: begin
                  if (c == cfg.preamble_second) begin
                     phase_in = PH_TYPE;
                     sum_in   = sum_next;
                  end else begin
                     phase_in = PH_IDLE;
                     timer_in = 1'b0;
                  end
               end
               PH_TYPE: begin
                  type_in  = c;
                  sum_in   = sum_next;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  len_in   = c;
                  sum_in   = sum_next;
                  count_in = '0;
                  phase_in = PH_ID;
               end
               PH_ID: begin
                  id_in    = c;
                  sum_in   = sum_next;
                  phase_in = PH_PAD;
               end
               PH_PAD: begin
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  sum_in    = sum_next;
                  count_in  = count_next;
                  res_valid = 1'b1;
                  if (count_next == CNT_FULL) begin
                     // buffer full: drop the frame
                     phase_in = PH_IDLE;
                     timer_in = 1'b0;
                  end else begin
                     if (9'(count_next) == {1'b0, len_ff}) begin
                        phase_in = PH_CSUM;
                     end
                     res.kind          = KIND_PAYLOAD;
                     res.payload_byte  = c;
                     res.payload_index = 6'(count_ff);
                  end
               end
               PH_CSUM: begin
                  phase_in  = PH_IDLE;
                  timer_in  = 1'b0;
                  res_valid = 1'b1;
                  res.kind  = (sum_next == 8'd0) ? KIND_GOOD : KIND_BAD;
               end
               default: begin
                  phase_in = PH_IDLE;
                  timer_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         sum_ff   <= 8'd0;
         type_ff  <= 8'd0;
         len_ff   <= 8'd0;
         id_ff    <= 8'd0;
         ticks_ff <= 16'd0;
         timer_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         ticks_ff <= ticks_in;
         timer_ff <= timer_in;
      end
   end

   // a stopped timer always holds a cleared count
   a_timer_clear: assert property (@(posedge clock) disable iff (reset)
      !timer_ff |-> ticks_ff == 16'd0)
      else $error("tick count nonzero while timer stopped");

   // idle is only reached through a path that stops the timer
   a_idle_stopped: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !timer_ff)
      else $error("timer running in idle phase");

   // payload count never sits at the buffer limit while collecting
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> count_ff < CNT_FULL)
      else $error("payload count at buffer limit in data phase");

   // a tick yields a result only when the timer was running
   a_tick_abort: assert property (@(posedge clock) disable iff (reset)
      step_valid && item.func == FUNC_TICK && res_valid |-> timer_ff && res.kind == KIND_ABORT)
      else $error("tick result without running timer");

endmodule
`default_nettype wire

// ===== rtl/serial_packet_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_packet_deframer: byte-stream frame parser with additive checksum
// Hunts for a two-byte preamble, reads type/length/id/pad, reports each
// payload byte, then checks the 8-bit sum; ticks drive an inter-byte timeout.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+-----------------
//  req     | req_valid req_ready req_data   | in        | valid/ready
//  rsp     | rsp_valid rsp_ready rsp_data   | out       | valid/ready
//  csr     | csr_we csr_index csr_wdata     | in        | write enable only
//
//  One item per cycle sustained while rsp is not stalled; a transfer on req
//  reaches rsp through the input register, then the parser step into the
//  output register. Items that produce no result still take a parser step.
//  A stalled rsp holds the output register; req_ready falls once the input
//  register is also occupied, so nothing is dropped.
//  Synchronous active-high reset clears parse state, timer and both valids;
//  config registers return to preamble 0xAA/0x55 and timeout 10 ticks.
// ----------------------------------------------------------------------------
module serial_packet_deframer #(
   parameter int unsigned BUFFER_BYTES = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire sdf_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output sdf_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [sdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sdf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sdf_pkg::*;

   cfg_type cfg;
   req_type item;
   rsp_type res;
   logic    item_valid;
   logic    res_valid;
   logic    out_free;
   logic    step_valid;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // output slot can take a new result when empty or being drained now
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign step_valid = item_valid && out_free;

   sdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   sdf_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_valid (step_valid),
      .item       (item),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register
   assign rsp_valid_in = out_free ? (step_valid && res_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== bench/tb_serial_packet_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_serial_packet_deframer: self-checking bench for the packet deframer
// A queue-fed driver streams bytes and ticks, a predictor tracks frame state
// per transfer, and a monitor checks every result against the prediction.
// ----------------------------------------------------------------------------
module tb_serial_packet_deframer;
   import sdf_pkg::*;

   localparam int unsigned BUF_BYTES    = 64;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned SETTLE_TICKS = 8;      // pipeline is two deep
   localparam int unsigned SEG_ITEMS    = 325;    // six segments of random items
   localparam int unsigned PRINT_CAP    = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   serial_packet_deframer #(.BUFFER_BYTES(BUF_BYTES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shared bench state
   // ------------------------------------------------------------------------
   req_type     rx_stream[$];           // items waiting for the driver
   rsp_type     predicted_results[$];   // results owed by the block, oldest first
   int unsigned queued_items = 0;
   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   // register shadow, starts at the reset values
   cfg_type csr_shadow = '{preamble_first:  PREAMBLE_FIRST_RST,
                           preamble_second: PREAMBLE_SECOND_RST,
                           timeout_ticks:   TIMEOUT_TICKS_RST};

   // predicted frame state, starts at the reset values
   phase_type   phase    = PH_IDLE;
   int unsigned pay_cnt  = 0;
   logic [7:0]  run_sum  = 8'h00;
   logic [7:0]  h_type   = 8'h00;
   logic [7:0]  h_len    = 8'h00;
   logic [7:0]  h_id     = 8'h00;
   logic [15:0] tick_cnt = 16'h0000;
   bit          tmr_on   = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor: one item in, at most one result out
   // ------------------------------------------------------------------------
   function automatic void drop_to_idle();
      phase    = PH_IDLE;
      tmr_on   = 1'b0;
      tick_cnt = 16'h0000;
   endfunction

   function automatic bit deframe_step(input req_type item, output rsp_type res);
      bit          fire;
      logic [1:0]  k;
      logic [7:0]  pb;
      logic [5:0]  pi;
      logic [7:0]  b;
      logic [7:0]  total;
      int unsigned idx;
      fire  = 1'b0;
      k     = KIND_PAYLOAD;
      pb    = 8'h00;
      pi    = 6'd0;
      b     = item.rx_byte;
      if (item.func == FUNC_TICK) begin
         // ticks only matter while a frame is in progress
         if (tmr_on) begin
            if (tick_cnt != TICKS_MAX) tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= csr_shadow.timeout_ticks) begin
               drop_to_idle();
               fire = 1'b1;
               k    = KIND_ABORT;
            end
         end
      end else begin
         // any byte restarts the inter-byte timer
         tmr_on   = 1'b1;
         tick_cnt = 16'h0000;
         case (phase)
            PH_IDLE: begin
               if (b == csr_shadow.preamble_first) begin
                  phase   = PH_PRE2;
                  run_sum = b;
               end else begin
                  drop_to_idle();
               end
            end
            PH_PRE2: begin
               if (b == csr_shadow.preamble_second) begin
                  phase   = PH_TYPE;
                  run_sum = run_sum + b;
               end else begin
                  drop_to_idle();
               end
            end
            PH_TYPE: begin
               h_type  = b;
               run_sum = run_sum + b;
               phase   = PH_LEN;
            end
            PH_LEN: begin
               h_len   = b;
               run_sum = run_sum + b;
               pay_cnt = 0;
               phase   = PH_ID;
            end
            PH_ID: begin
               h_id    = b;
               run_sum = run_sum + b;
               phase   = PH_PAD;
            end
            PH_PAD: begin
               phase = PH_DATA;            // pad is not summed
            end
            PH_DATA: begin
               idx     = pay_cnt;
               run_sum = run_sum + b;
               pay_cnt = pay_cnt + 1;
               fire    = 1'b1;
               if (pay_cnt >= BUF_BYTES) begin
                  // buffer full: abort replaces the payload result
                  drop_to_idle();
                  k = KIND_ABORT;
               end else begin
                  if (pay_cnt == h_len) phase = PH_CSUM;
                  pb = b;
                  pi = idx[5:0];
               end
            end
            PH_CSUM: begin
               total = run_sum + b;
               k     = (total == 8'h00) ? KIND_GOOD : KIND_BAD;
               fire  = 1'b1;
               drop_to_idle();
            end
            default: drop_to_idle();
         endcase
      end
      res.kind          = k;
      res.payload_byte  = pb;
      res.payload_index = pi;
      res.frame_type    = h_type;
      res.frame_length  = h_len;
      res.frame_id      = h_id;
      return fire;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: predicts on every accepted transfer, then presents the next item
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive
      rsp_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (deframe_step(req_data, res)) predicted_results.push_back(res);
         end
         if (!req_valid || req_ready) begin
            if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= rx_stream.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result transfer, randomizes backpressure
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp_data.kind, 0);
            end else begin
               want = predicted_results.pop_front();
               check_field("kind", rsp_data.kind, want.kind);
               check_field("payload_byte", rsp_data.payload_byte, want.payload_byte);
               check_field("payload_index", rsp_data.payload_index, want.payload_index);
               check_field("frame_type", rsp_data.frame_type, want.frame_type);
               check_field("frame_length", rsp_data.frame_length, want.frame_length);
               check_field("frame_id", rsp_data.frame_id, want.frame_id);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired at cycle %0d", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      req_type it;
      it.func    = FUNC_BYTE;
      it.rx_byte = b;
      rx_stream.push_back(it);
      queued_items++;
   endtask

   task automatic push_ticks(input int unsigned n);
      req_type it;
      it.func = FUNC_TICK;
      repeat (n) begin
         it.rx_byte = 8'($urandom);   // ignored by the block, exercised anyway
         rx_stream.push_back(it);
         queued_items++;
      end
   endtask

   // every queued item transferred, every result back, pipeline flushed
   task automatic wait_drained();
      while (rx_stream.size() != 0 || req_valid || predicted_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PREAMBLE_FIRST:  csr_shadow.preamble_first  = val[7:0];
         CSR_PREAMBLE_SECOND: csr_shadow.preamble_second = val[7:0];
         CSR_TIMEOUT_TICKS:   csr_shadow.timeout_ticks   = val;
         default: ;
      endcase
   endtask

   task automatic set_link_config(input logic [7:0] p1, input logic [7:0] p2,
                                  input logic [15:0] limit);
      csr_write(CSR_PREAMBLE_FIRST, {8'h00, p1});
      csr_write(CSR_PREAMBLE_SECOND, {8'h00, p2});
      csr_write(CSR_TIMEOUT_TICKS, limit);
   endtask

   // a few ticks between bytes, short of the timeout
   task automatic maybe_gap();
      int unsigned hi;
      if (csr_shadow.timeout_ticks > 1 && $urandom_range(7) == 0) begin
         hi = csr_shadow.timeout_ticks - 1;
         if (hi > 6) hi = 6;
         push_ticks($urandom_range(1, hi));
      end
   endtask

   // Whole frame with random content. Lengths of zero or at least the buffer
   // size get exactly enough payload to fill the buffer, which aborts.
   // 0 < cut < frame size stops after cut bytes and lets the timer expire.
   task automatic send_frame(input logic [7:0] len, input bit corrupt,
                             input int unsigned cut);
      logic [7:0]  frame[$];
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned body;
      int unsigned n;
      body = (len == 0 || len >= BUF_BYTES) ? BUF_BYTES : len;
      frame.push_back(csr_shadow.preamble_first);
      frame.push_back(csr_shadow.preamble_second);
      frame.push_back(8'($urandom));     // type
      frame.push_back(len);
      frame.push_back(8'($urandom));     // id
      sum = frame[0] + frame[1] + frame[2] + frame[3] + frame[4];
      frame.push_back(8'($urandom));     // pad, not summed
      repeat (body) begin
         b = 8'($urandom);
         sum = sum + b;
         frame.push_back(b);
      end
      if (body < BUF_BYTES) begin
         b = 8'h00 - sum;
         if (corrupt) b = b ^ 8'($urandom_range(1, 255));
         frame.push_back(b);
      end
      n = (cut != 0 && cut < frame.size()) ? cut : frame.size();
      for (int unsigned i = 0; i < n; i++) begin
         push_byte(frame[i]);
         if (i + 1 < n) maybe_gap();
      end
      if (n < frame.size()) push_ticks(csr_shadow.timeout_ticks);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned seg_start;
      int unsigned pick;
      bit          paused;
      logic [7:0]  p;

      while (reset) @(negedge clock);

      // Directed checks at the reset register values (0xAA/0x55, 10 ticks).
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      push_ticks(1);                         // tick with the timer stopped
      push_byte(8'h00);                      // stray bytes while hunting
      push_byte(8'hFF);
      push_byte(8'hAA);                      // wrong second preamble
      push_byte(8'h00);
      push_ticks(1);
      // good frame, type 0xFF, length 2, id 0x00, payload 00 FF
      push_byte(8'hAA); push_byte(8'h55); push_byte(8'hFF); push_byte(8'h02);
      push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
      push_byte(8'h01);
      // checksum error, type 0x00, length 1, id 0xFF, payload 80
      push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00); push_byte(8'h01);
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80); push_byte(8'h80);
      // timer restarted by a byte just short of expiry, then timeout
      push_byte(8'hAA); push_byte(8'h55);
      push_ticks(9);
      push_byte(8'h12);
      push_ticks(10);
      wait_drained();

      // Random segments: own register setting each, idle pattern per pair.
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0:       begin send_idle_pct = 38; recv_stall_pct = 75; end
            1:       begin send_idle_pct = 75; recv_stall_pct = 38; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         case (seg)
            0: set_link_config(8'h00, 8'hFF, 16'd1);
            1: set_link_config(8'hFF, 8'h00, 16'($urandom_range(2, 12)));
            2: set_link_config(8'($urandom), 8'($urandom),
                               16'($urandom_range(2, 40)));
            3: begin
               p = 8'($urandom);                 // same value for both preambles
               set_link_config(p, p, 16'($urandom_range(3, 20)));
            end
            4: set_link_config(8'($urandom), 8'($urandom), 16'hFFFF);
            default: set_link_config(8'($urandom), 8'($urandom),
                                     16'($urandom_range(1, 8)));
         endcase

         seg_start = queued_items;
         paused    = 1'b0;
         if (seg == 0) begin
            // empty and overlong declared lengths run into the buffer limit
            send_frame(8'd0, 1'b0, 0);
            send_frame(8'(BUF_BYTES), 1'b0, 0);
            send_frame(8'd200, 1'b0, 0);
         end
         if (seg == 4) begin
            // long silence mid-frame, far short of the maximum timeout
            push_byte(csr_shadow.preamble_first);
            push_ticks(40);
         end

         while (queued_items - seg_start < SEG_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
               send_frame(($urandom_range(9) == 0) ? 8'($urandom_range(13, 63))
                                                   : 8'($urandom_range(1, 12)),
                          ($urandom_range(6) == 0), 0);
            end else if (pick < 75) begin
               case ($urandom_range(2))
                  0:       send_frame(8'd0, 1'b0, 0);
                  1:       send_frame(8'(BUF_BYTES), 1'b0, 0);
                  default: send_frame(8'($urandom_range(BUF_BYTES + 1, 255)), 1'b0, 0);
               endcase
            end else if (pick < 85) begin
               // truncated frame; only worth it when the timeout is short
               if (csr_shadow.timeout_ticks <= 40)
                  send_frame(8'($urandom_range(1, 8)), 1'b0, $urandom_range(1, 12));
               else
                  send_frame(8'($urandom_range(1, 8)), 1'b0, 0);
            end else if (pick < 92) begin
               push_byte(csr_shadow.preamble_first);
               push_byte(csr_shadow.preamble_second ^ 8'($urandom_range(1, 255)));
            end else begin
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(1) == 0) push_ticks(1);
                  else push_byte(8'($urandom));
               end
            end
            // sender holds off mid-segment until every result is back
            if (!paused && queued_items - seg_start >= SEG_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
